>>> hdl/xkb64_pkg.sv
package xkb64_pkg;

   localparam int KeyBytesMax = 8;
   localparam int KeyIdxW     = 3;
   localparam int DataW       = 8;
   localparam int AccW        = 16;
   localparam int FillW       = 3;
   localparam int KeyW        = 64;
   localparam int KeyLenW     = 4;
   localparam int CsrAddrW    = 5;
   localparam int CsrDataW    = 64;
   localparam int GroupMax    = 4;
   localparam int GroupCntW   = 3;
   localparam int GroupPosW   = 2;

   localparam logic [1:0] REG_MODE    = 2'd0;
   localparam logic [1:0] REG_KEY     = 2'd1;
   localparam logic [1:0] REG_KEY_LEN = 2'd2;

   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   localparam logic [7:0] CHAR_PAD   = 8'h3D;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;

   typedef struct packed {
      logic [KeyIdxW-1:0] key_index;
      logic [AccW-1:0]    bit_accum;
      logic [FillW-1:0]   fill_count;
      logic               pad_seen;
   } msg_state_type;

   typedef struct packed {
      logic [GroupMax-1:0][DataW-1:0] bytes;
      logic [GroupCntW-1:0]           count;
      logic                           byte_valid;
      logic                           last;
   } rsp_group_type;

   function automatic logic [7:0] b64_char(input logic [5:0] v);
      logic [7:0] w;
      w = {2'b00, v};
      if (w < 8'd26) begin
         return w + 8'h41;
      end else if (w < 8'd52) begin
         return w + 8'd71;
      end else if (w < 8'd62) begin
         return w - 8'd4;
      end else if (w == 8'd62) begin
         return CHAR_PLUS;
      end else begin
         return CHAR_SLASH;
      end
   endfunction

   // Bit 6 flags a character of the alphabet, bits 5..0 carry its value.
   function automatic logic [6:0] b64_value(input logic [7:0] c);
      logic [7:0] w;
      w = 8'h00;
      if (c >= 8'h41 && c <= 8'h5A) begin
         w = c - 8'h41;
         return {1'b1, w[5:0]};
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         w = c - 8'd71;
         return {1'b1, w[5:0]};
      end else if (c >= 8'h30 && c <= 8'h39) begin
         w = c + 8'd4;
         return {1'b1, w[5:0]};
      end else if (c == CHAR_PLUS) begin
         return {1'b1, 6'd62};
      end else if (c == CHAR_SLASH) begin
         return {1'b1, 6'd63};
      end else begin
         return {1'b0, w[5:0]};
      end
   endfunction

endpackage

>>> hdl/xkb64_if.sv
interface xkb64_req_if;
   logic                           valid;
   logic                           ready;
   logic [xkb64_pkg::DataW-1:0]    byte_in;
   logic                           last_in;

   modport source (output valid, output byte_in, output last_in, input ready);
   modport sink (input valid, input byte_in, input last_in, output ready);
endinterface

interface xkb64_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [xkb64_pkg::DataW-1:0]    byte_out;
   logic                           byte_valid;
   logic                           last_out;

   modport source (output valid, output byte_out, output byte_valid, output last_out,
                   input ready);
   modport sink (input valid, input byte_out, input byte_valid, input last_out,
                 output ready);
endinterface

>>> hdl/xkb64_core.sv
module xkb64_core #(
   parameter int KEY_BYTES = xkb64_pkg::KeyBytesMax
) (
   input  logic                             mode,
   input  logic [xkb64_pkg::KeyW-1:0]       key_bytes,
   input  logic [xkb64_pkg::KeyLenW-1:0]    key_len,
   input  xkb64_pkg::msg_state_type         st,
   input  logic [xkb64_pkg::DataW-1:0]      byte_in,
   input  logic                             last_in,
   output xkb64_pkg::msg_state_type         st_nxt,
   output xkb64_pkg::rsp_group_type         grp
);

   logic [xkb64_pkg::KeyLenW-1:0]  eff_len;
   logic [xkb64_pkg::DataW-1:0]    key_byte;
   logic [xkb64_pkg::KeyLenW-1:0]  idx_inc;
   logic [xkb64_pkg::KeyIdxW-1:0]  idx_next;

   always_comb begin
      if (key_len == '0) begin
         eff_len = 4'd1;
      end else if (key_len > 4'(KEY_BYTES)) begin
         eff_len = 4'(KEY_BYTES);
      end else begin
         eff_len = key_len;
      end
      key_byte = key_bytes[{st.key_index, 3'b000} +: 8];
      idx_inc  = {1'b0, st.key_index} + 4'd1;
      idx_next = (idx_inc >= eff_len) ? '0 : idx_inc[xkb64_pkg::KeyIdxW-1:0];
   end

   always_comb begin
      logic [7:0]  x;
      logic [23:0] t;
      logic [6:0]  dv;
      logic [3:0]  bits;
      logic [3:0]  bits_after;
      logic [11:0] acc12;
      logic [11:0] mask;
      logic [2:0]  sh;
      logic [7:0]  v;
      logic        emit;

      st_nxt         = st;
      grp            = '0;
      grp.byte_valid = 1'b1;
      x              = byte_in ^ key_byte;
      t              = '0;
      dv             = xkb64_pkg::b64_value(byte_in);
      bits           = {1'b0, st.fill_count} + 4'd6;
      acc12          = {st.bit_accum[5:0], dv[5:0]};
      emit           = bits >= 4'd8;
      sh             = 3'(bits - 4'd8);
      v              = 8'(acc12 >> sh) ^ key_byte;
      bits_after     = emit ? bits - 4'd8 : bits;
      if (bits_after > 4'd6) begin
         bits_after = 4'd6;
      end
      mask = (12'd1 << bits_after) - 12'd1;

      if (mode == xkb64_pkg::MODE_ENCODE) begin
         st_nxt.key_index = idx_next;
         if (st.fill_count >= 3'd2) begin
            t = {st.bit_accum, x};
         end else if (st.fill_count == 3'd1) begin
            t = {st.bit_accum[7:0], x, 8'h00};
         end else begin
            t = {x, 16'h0000};
         end
         grp.bytes[0] = xkb64_pkg::b64_char(t[23:18]);
         grp.bytes[1] = xkb64_pkg::b64_char(t[17:12]);
         grp.bytes[2] = (st.fill_count == 3'd0) ? xkb64_pkg::CHAR_PAD
                                                : xkb64_pkg::b64_char(t[11:6]);
         grp.bytes[3] = (st.fill_count < 3'd2) ? xkb64_pkg::CHAR_PAD
                                               : xkb64_pkg::b64_char(t[5:0]);
         if (st.fill_count >= 3'd2) begin
            grp.count         = 3'd4;
            st_nxt.bit_accum  = '0;
            st_nxt.fill_count = '0;
         end else begin
            st_nxt.bit_accum  = (st.fill_count == 3'd0) ? {8'h00, x}
                                                        : {st.bit_accum[7:0], x};
            st_nxt.fill_count = st.fill_count + 3'd1;
            grp.count         = last_in ? 3'd4 : 3'd0;
         end
         grp.last = last_in;
      end else begin
         if (!st.pad_seen) begin
            if (byte_in == xkb64_pkg::CHAR_PAD) begin
               st_nxt.pad_seen = 1'b1;
            end else if (dv[6]) begin
               if (emit) begin
                  grp.bytes[0]     = v;
                  grp.count        = 3'd1;
                  st_nxt.key_index = idx_next;
               end
               st_nxt.bit_accum  = {4'h0, acc12 & mask};
               st_nxt.fill_count = bits_after[2:0];
            end
         end
         if (last_in && grp.count == 3'd0) begin
            // Nothing decoded on the final request: send a bare end marker.
            grp.bytes[0]   = 8'h00;
            grp.byte_valid = 1'b0;
            grp.count      = 3'd1;
         end
         grp.last = last_in;
      end

      if (last_in) begin
         st_nxt = '0;
      end
   end

endmodule

>>> hdl/xor_keyed_base64_codec.sv
// Channel   Direction  Payload                           Handshake
// req_ch    in         byte_in[7:0], last_in             valid / ready
// rsp_ch    out        byte_out[7:0], byte_valid, last_out  valid / ready
// csr_*     in/out     mode @0x00, key_bytes @0x08, key_len @0x10  APB, pready high
//
// A request is registered, then processed into a result group of up to four items
// in the group register, which drains one item per cycle while rsp_ch is not stalled.
// Decode sustains one request per cycle while rsp_ch is not stalled. In encode, a
// request waits until the four-character group has left the group register.
// Synchronous reset clears all control state; no clearing pass.
// A stall on rsp_ch holds the group and, once the input register is full, drops ready.
module xor_keyed_base64_codec #(
   parameter int KEY_BYTES = xkb64_pkg::KeyBytesMax
) (
   input  logic                               clock,
   input  logic                               reset,
   xkb64_req_if.sink                          req_ch,
   xkb64_rsp_if.source                        rsp_ch,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [xkb64_pkg::CsrAddrW-1:0]     csr_paddr,
   input  logic [xkb64_pkg::CsrDataW-1:0]     csr_pwdata,
   output logic [xkb64_pkg::CsrDataW-1:0]     csr_prdata,
   output logic                               csr_pready
);

   logic                              mode_ff;
   logic [xkb64_pkg::KeyW-1:0]        key_ff;
   logic [xkb64_pkg::KeyLenW-1:0]     key_len_ff;
   logic [1:0]                        csr_index;
   logic                              csr_write;

   xkb64_pkg::msg_state_type          state_ff, state_in;
   logic                              in_valid_ff, in_valid_in;
   logic [xkb64_pkg::DataW-1:0]       in_byte_ff;
   logic                              in_last_ff;

   xkb64_pkg::rsp_group_type          grp_new;
   logic [xkb64_pkg::GroupMax-1:0][xkb64_pkg::DataW-1:0] grp_bytes_ff;
   logic [xkb64_pkg::GroupCntW-1:0]   grp_left_ff, grp_left_in;
   logic [xkb64_pkg::GroupPosW-1:0]   grp_pos_ff, grp_pos_in;
   logic                              grp_bval_ff;
   logic                              grp_last_ff;

   logic                              req_fire;
   logic                              rsp_fire;
   logic                              grp_free;
   logic                              advance;
   logic                              grp_load;

   assign csr_index  = csr_paddr[4:3];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      unique case (csr_index)
         xkb64_pkg::REG_MODE:    csr_prdata = {63'h0, mode_ff};
         xkb64_pkg::REG_KEY:     csr_prdata = key_ff;
         xkb64_pkg::REG_KEY_LEN: csr_prdata = {60'h0, key_len_ff};
         default:                csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= xkb64_pkg::MODE_ENCODE;
         key_ff     <= '0;
         key_len_ff <= 4'd1;
      end else if (csr_write) begin
         if (csr_index == xkb64_pkg::REG_MODE) begin
            mode_ff <= csr_pwdata[0];
         end
         if (csr_index == xkb64_pkg::REG_KEY) begin
            key_ff <= csr_pwdata;
         end
         if (csr_index == xkb64_pkg::REG_KEY_LEN) begin
            key_len_ff <= csr_pwdata[xkb64_pkg::KeyLenW-1:0];
         end
      end
   end

   assign rsp_fire = rsp_ch.valid && rsp_ch.ready;
   assign grp_free = (grp_left_ff == 3'd0) || (grp_left_ff == 3'd1 && rsp_ch.ready);
   assign advance  = in_valid_ff && grp_free;
   assign grp_load = advance && (grp_new.count != 3'd0);

   assign req_ch.ready = !in_valid_ff || advance;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign in_valid_in  = req_fire || (in_valid_ff && !advance);

   xkb64_core #(
      .KEY_BYTES (KEY_BYTES)
   ) u_core (
      .mode      (mode_ff),
      .key_bytes (key_ff),
      .key_len   (key_len_ff),
      .st        (state_ff),
      .byte_in   (in_byte_ff),
      .last_in   (in_last_ff),
      .st_nxt    (state_in),
      .grp       (grp_new)
   );

   always_comb begin
      grp_left_in = grp_left_ff;
      grp_pos_in  = grp_pos_ff;
      if (grp_load) begin
         grp_left_in = grp_new.count;
         grp_pos_in  = '0;
      end else if (rsp_fire) begin
         grp_left_in = grp_left_ff - 3'd1;
         grp_pos_in  = grp_pos_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         grp_left_ff <= '0;
         grp_pos_ff  <= '0;
         state_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         grp_left_ff <= grp_left_in;
         grp_pos_ff  <= grp_pos_in;
         // A mode write restarts the message from an empty state.
         if (csr_write && csr_index == xkb64_pkg::REG_MODE) begin
            state_ff <= '0;
         end else if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_ch.byte_in;
         in_last_ff <= req_ch.last_in;
      end
      if (grp_load) begin
         grp_bytes_ff <= grp_new.bytes;
         grp_bval_ff  <= grp_new.byte_valid;
         grp_last_ff  <= grp_new.last;
      end
   end

   assign rsp_ch.valid      = grp_left_ff != 3'd0;
   assign rsp_ch.byte_out   = grp_bytes_ff[grp_pos_ff];
   assign rsp_ch.byte_valid = grp_bval_ff;
   assign rsp_ch.last_out   = grp_last_ff && (grp_left_ff == 3'd1);

endmodule

>>> hdl/xkb64_checker.sv
module xkb64_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [xkb64_pkg::DataW-1:0]   rsp_byte_out,
   input logic                          rsp_byte_valid,
   input logic                          rsp_last_out
);

   // A result that is offered stays offered, unchanged, until it is taken.
   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_byte_out)
            && $stable(rsp_byte_valid) && $stable(rsp_last_out);
   endproperty
   a_rsp_hold: assert property (p_rsp_hold)
      else $error("result changed while stalled");

   // Nothing is offered in the cycle after reset.
   property p_reset_idle;
      @(posedge clock) reset |=> !rsp_valid;
   endproperty
   a_reset_idle: assert property (p_reset_idle)
      else $error("result offered right after reset");

   // A bare end marker always closes the message.
   property p_marker_last;
      @(posedge clock) disable iff (reset)
         rsp_valid && !rsp_byte_valid |-> rsp_last_out && rsp_byte_out == 8'h00;
   endproperty
   a_marker_last: assert property (p_marker_last)
      else $error("end marker without last or with data");

   // Every field of an offered result carries a defined value.
   property p_rsp_known;
      @(posedge clock) disable iff (reset)
         rsp_valid |-> !$isunknown({rsp_byte_out, rsp_byte_valid, rsp_last_out});
   endproperty
   a_rsp_known: assert property (p_rsp_known)
      else $error("result offered with undefined fields");

endmodule

bind xor_keyed_base64_codec xkb64_checker u_xkb64_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_byte_out   (rsp_ch.byte_out),
   .rsp_byte_valid (rsp_ch.byte_valid),
   .rsp_last_out   (rsp_ch.last_out)
);
